// ===== rtl/bor_pkg.sv =====
// Package for the byte offset reorder buffer.
// Holds buffer sizing, word and entry types, the sequencer states and the
// lowest-set-bit encoder. No dependencies.
package bor_pkg;

    localparam int BUFFER_DEPTH = 8;
    localparam int MAX_PAYLOAD  = 1024;

    localparam int IDX_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int OFF_W  = 32;
    localparam int SIZE_W = 11;
    localparam int TAG_W  = 8;

    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_PAYLOAD);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DELIV,
        S_SCAN,
        S_ACK
    } t_state;

    typedef enum logic {
        KIND_DELIVER = 1'b0,
        KIND_ACK     = 1'b1
    } t_kind;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
        logic              last;
        logic [TAG_W-1:0]  chan;
        logic [TAG_W-1:0]  hdl;
    } t_pkt;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  hdl;
        logic [TAG_W-1:0]  chan;
    } t_entry;

    typedef struct packed {
        t_kind             kind;
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  hdl;
        logic [TAG_W-1:0]  chan;
        logic              is_last;
        logic              last_result;
    } t_out;

    function automatic logic [IDX_W-1:0] lowest_set(input logic [BUFFER_DEPTH-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = BUFFER_DEPTH - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/byte_offset_reorder_buffer.sv =====
// Byte offset reorder buffer: in-order delivery, parking of early packets,
// drain of parked entries and acknowledgement. Depends on bor_pkg.
//
//  channel  dir  tdata (low bit up)                             tuser  tlast
//  s        in   seq_offset, byte_count, channel, payload_handle -     is_last_pkt
//  m        out  out_offset, out_size, out_handle, out_channel,  kind   last_result
//                out_is_last_pkt
//
// A dropped packet stays in idle, an early one visits ack, an in-order one deliver,
// scan and ack; the scan tests one valid entry at a time from the lowest, restarting
// after each delivery. One shared comparator and adder does all offset work.
// Reset is synchronous active low and clears the expected offset and all
// valid bits at once. A stalled output word holds the sequencer at its next emit.
module byte_offset_reorder_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // seq_offset, byte_count, channel, payload_handle
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // out_offset, out_size, out_handle, out_channel,
                                     // out_is_last_pkt
    output logic [0:0]  o_m_tuser,   // kind
    output logic        o_m_tlast
);

    bor_pkg::t_state r_state, n_state;
    bor_pkg::t_pkt   r_pkt, n_pkt;
    bor_pkg::t_out   r_out, n_out;
    bor_pkg::t_entry r_ent [bor_pkg::BUFFER_DEPTH];

    logic                            r_ovalid, n_ovalid;
    logic [bor_pkg::OFF_W-1:0]       r_expected, n_expected;
    logic [bor_pkg::BUFFER_DEPTH-1:0] r_valid, n_valid;
    logic [bor_pkg::BUFFER_DEPTH-1:0] r_scan_mask, n_scan_mask;

    logic [bor_pkg::OFF_W-1:0]  w_in_off;
    logic [bor_pkg::SIZE_W-1:0] w_in_size_raw;
    logic [bor_pkg::SIZE_W-1:0] w_in_size;
    logic [bor_pkg::TAG_W-1:0]  w_in_chan;
    logic [bor_pkg::TAG_W-1:0]  w_in_hdl;
    logic                       w_accept;
    logic                       w_out_free;
    logic [bor_pkg::IDX_W-1:0]  w_scan_idx;
    logic [bor_pkg::IDX_W-1:0]  w_free_idx;
    logic                       w_has_free;
    bor_pkg::t_entry            w_ent;
    logic [bor_pkg::OFF_W-1:0]  w_cmp_a;
    logic                       w_match;
    logic [bor_pkg::SIZE_W-1:0] w_add_b;
    logic [bor_pkg::OFF_W-1:0]  w_sum;
    logic                       w_wr_en;

    assign w_in_off      = i_s_tdata[31:0];
    assign w_in_size_raw = i_s_tdata[42:32];
    assign w_in_chan     = i_s_tdata[50:43];
    assign w_in_hdl      = i_s_tdata[58:51];
    assign w_in_size     = (w_in_size_raw > bor_pkg::MAX_SIZE) ? bor_pkg::MAX_SIZE
                                                              : w_in_size_raw;

    assign o_s_tready = (r_state == bor_pkg::S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_ovalid || i_m_tready;

    assign w_scan_idx = bor_pkg::lowest_set(r_scan_mask);
    assign w_free_idx = bor_pkg::lowest_set(~r_valid);
    assign w_has_free = |(~r_valid);
    assign w_ent      = r_ent[w_scan_idx];

    // shared compare and add unit
    assign w_cmp_a = (r_state == bor_pkg::S_IDLE) ? w_in_off : w_ent.off;
    assign w_match = (w_cmp_a == r_expected);
    assign w_add_b = (r_state == bor_pkg::S_DELIV) ? r_pkt.size : w_ent.size;
    assign w_sum   = r_expected + bor_pkg::OFF_W'(w_add_b);

    assign w_wr_en = w_accept && !w_match && w_has_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bor_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_match) begin
                        n_state = bor_pkg::S_DELIV;
                    end else if (w_has_free) begin
                        n_state = bor_pkg::S_ACK;
                    end
                end
            end
            bor_pkg::S_DELIV: begin
                if (w_out_free) begin
                    n_state = bor_pkg::S_SCAN;
                end
            end
            bor_pkg::S_SCAN: begin
                if (r_scan_mask == '0) begin
                    n_state = bor_pkg::S_ACK;
                end
            end
            bor_pkg::S_ACK: begin
                if (w_out_free) begin
                    n_state = bor_pkg::S_IDLE;
                end
            end
            default: n_state = bor_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_pkt       = r_pkt;
        n_out       = r_out;
        n_ovalid    = r_ovalid && !i_m_tready;
        n_expected  = r_expected;
        n_valid     = r_valid;
        n_scan_mask = r_scan_mask;
        unique case (r_state)
            bor_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_pkt.off  = w_in_off;
                    n_pkt.size = w_in_size;
                    n_pkt.last = i_s_tlast;
                    n_pkt.chan = w_in_chan;
                    n_pkt.hdl  = w_in_hdl;
                    if (w_wr_en) begin
                        n_valid[w_free_idx] = 1'b1;
                    end
                end
            end
            bor_pkg::S_DELIV: begin
                if (w_out_free) begin
                    n_ovalid          = 1'b1;
                    n_out.kind        = bor_pkg::KIND_DELIVER;
                    n_out.off         = r_pkt.off;
                    n_out.size        = r_pkt.size;
                    n_out.hdl         = r_pkt.hdl;
                    n_out.chan        = r_pkt.chan;
                    n_out.is_last     = 1'b0;
                    n_out.last_result = 1'b0;
                    n_expected        = w_sum;
                    n_scan_mask       = r_valid;
                end
            end
            bor_pkg::S_SCAN: begin
                if (r_scan_mask != '0) begin
                    if (w_match) begin
                        if (w_out_free) begin
                            n_ovalid              = 1'b1;
                            n_out.kind            = bor_pkg::KIND_DELIVER;
                            n_out.off             = w_ent.off;
                            n_out.size            = w_ent.size;
                            n_out.hdl             = w_ent.hdl;
                            n_out.chan            = w_ent.chan;
                            n_out.is_last         = 1'b0;
                            n_out.last_result     = 1'b0;
                            n_expected            = w_sum;
                            n_valid[w_scan_idx]   = 1'b0;
                            n_scan_mask           = r_valid;
                            n_scan_mask[w_scan_idx] = 1'b0;
                        end
                    end else begin
                        n_scan_mask[w_scan_idx] = 1'b0;
                    end
                end
            end
            bor_pkg::S_ACK: begin
                if (w_out_free) begin
                    n_ovalid          = 1'b1;
                    n_out.kind        = bor_pkg::KIND_ACK;
                    n_out.off         = r_pkt.off;
                    n_out.size        = '0;
                    n_out.hdl         = '0;
                    n_out.chan        = r_pkt.chan;
                    n_out.is_last     = r_pkt.last;
                    n_out.last_result = 1'b1;
                    if (r_pkt.last) begin
                        n_expected = '0;
                        n_valid    = '0;
                    end
                end
            end
            default: begin
                n_ovalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bor_pkg::S_IDLE;
            r_ovalid    <= 1'b0;
            r_expected  <= '0;
            r_valid     <= '0;
            r_scan_mask <= '0;
        end else begin
            r_state     <= n_state;
            r_ovalid    <= n_ovalid;
            r_expected  <= n_expected;
            r_valid     <= n_valid;
            r_scan_mask <= n_scan_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt <= n_pkt;
        r_out <= n_out;
        if (w_wr_en) begin
            r_ent[w_free_idx] <= '{off: w_in_off, size: w_in_size,
                                   hdl: w_in_hdl, chan: w_in_chan};
        end
    end

    assign o_m_tvalid   = r_ovalid;
    assign o_m_tdata    = {4'b0, r_out.is_last, r_out.chan, r_out.hdl,
                           r_out.size, r_out.off};
    assign o_m_tuser[0] = r_out.kind;
    assign o_m_tlast    = r_out.last_result;

`ifndef SYNTHESIS
    a_last_marks_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == o_m_tuser[0]))
        else $error("last_result set on a word that is not an acknowledgement");

    a_ack_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[50:32] == '0))
        else $error("acknowledgement carries size or handle");

    a_scan_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bor_pkg::S_SCAN) |-> ((r_scan_mask & ~r_valid) == '0))
        else $error("scan visits an entry that is not valid");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bor_pkg::S_ACK && w_out_free && r_pkt.last)
            |=> (r_valid == '0 && r_expected == '0))
        else $error("final acknowledgement did not clear the buffer");

    a_stall_holds_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bor_pkg::S_DELIV && !w_out_free) |=> $stable(r_expected))
        else $error("expected offset moved while delivery stalled");
`endif

endmodule

// ===== tb/tb_byte_offset_reorder_buffer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for byte_offset_reorder_buffer: a software predictor checks
// ordered delivery, parking, drain, drop and ack words. Depends on bor_pkg and the DUT.
module tb_byte_offset_reorder_buffer;
    import bor_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 120;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata  = '0;   // seq_offset, byte_count, channel, payload_handle
    logic        i_s_tlast  = 1'b0; // is_last_pkt
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;         // out_offset, out_size, out_handle, out_channel,
                                    // out_is_last_pkt
    logic [0:0]  o_m_tuser;         // kind
    logic        o_m_tlast;         // last_result

    logic [OFF_W-1:0]        next_offset = '0;
    logic [BUFFER_DEPTH-1:0] slot_used   = '0;
    logic [OFF_W-1:0]        slot_off  [BUFFER_DEPTH];
    logic [SIZE_W-1:0]       slot_size [BUFFER_DEPTH];
    logic [TAG_W-1:0]        slot_hdl  [BUFFER_DEPTH];
    logic [TAG_W-1:0]        slot_chan [BUFFER_DEPTH];

    t_out pending_results[$];
    t_out got_word;
    t_out want_word;
    int   mismatch_count = 0;
    int   stall_cnt      = 0;
    int   rx_wait        = 0;
    int   rx_hold_len    = 0;
    bit   idle_on        = 1'b1;

    byte_offset_reorder_buffer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_pkt mk_pkt(input logic [OFF_W-1:0] off, input logic [SIZE_W-1:0] size,
                                    input logic last, input logic [TAG_W-1:0] chan,
                                    input logic [TAG_W-1:0] hdl);
        t_pkt p;
        p.off  = off;
        p.size = size;
        p.last = last;
        p.chan = chan;
        p.hdl  = hdl;
        return p;
    endfunction

    function automatic t_out mk_word(input t_kind kind, input logic [OFF_W-1:0] off,
                                     input logic [SIZE_W-1:0] size, input logic [TAG_W-1:0] hdl,
                                     input logic [TAG_W-1:0] chan, input logic is_last,
                                     input logic last_result);
        t_out w;
        w.kind        = kind;
        w.off         = off;
        w.size        = size;
        w.hdl         = hdl;
        w.chan        = chan;
        w.is_last     = is_last;
        w.last_result = last_result;
        return w;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] size);
        return (size > MAX_SIZE) ? MAX_SIZE : size;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return SIZE_W'($urandom_range(MAX_PAYLOAD + 1, 2047));
        return SIZE_W'($urandom_range(1, MAX_PAYLOAD));
    endfunction

    function automatic void reorder_predict(input t_pkt p);
        logic [SIZE_W-1:0] sz;
        int hit;
        int slot;
        sz = clamp_size(p.size);
        if (p.off == next_offset) begin
            pending_results.push_back(mk_word(KIND_DELIVER, p.off, sz, p.hdl, p.chan, 1'b0, 1'b0));
            next_offset += OFF_W'(sz);
            for (int round = 0; round < BUFFER_DEPTH; round++) begin
                hit = -1;
                for (int i = 0; i < BUFFER_DEPTH; i++) begin
                    if (hit < 0 && slot_used[i] && slot_off[i] == next_offset) hit = i;
                end
                if (hit < 0) break;
                pending_results.push_back(mk_word(KIND_DELIVER, slot_off[hit], slot_size[hit],
                                                  slot_hdl[hit], slot_chan[hit], 1'b0, 1'b0));
                next_offset += OFF_W'(slot_size[hit]);
                slot_used[hit] = 1'b0;
            end
        end else begin
            slot = -1;
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                if (slot < 0 && !slot_used[i]) slot = i;
            end
            if (slot < 0) return;
            slot_used[slot] = 1'b1;
            slot_off[slot]  = p.off;
            slot_size[slot] = sz;
            slot_hdl[slot]  = p.hdl;
            slot_chan[slot] = p.chan;
        end
        pending_results.push_back(mk_word(KIND_ACK, p.off, '0, '0, p.chan, p.last, 1'b1));
        if (p.last) begin
            next_offset = '0;
            slot_used   = '0;
        end
    endfunction

    // Entered and left at a falling edge.
    task automatic send_pkt(input t_pkt p);
        repeat (idle_on ? $urandom_range(0, 9) : 0) @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = {5'b0, p.hdl, p.chan, p.size, p.off};
        i_s_tlast  = p.last;
        do @(posedge i_clk); while (!o_s_tready);
        reorder_predict(p);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(negedge i_clk) begin
        if (rx_hold_len > 0) begin
            i_m_tready = 1'b0;
            rx_hold_len--;
        end else if (rx_wait > 0) begin
            i_m_tready = 1'b0;
            rx_wait--;
        end else begin
            i_m_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_word.kind        = t_kind'(o_m_tuser[0]);
            got_word.off         = o_m_tdata[31:0];
            got_word.size        = o_m_tdata[42:32];
            got_word.hdl         = o_m_tdata[50:43];
            got_word.chan        = o_m_tdata[58:51];
            got_word.is_last     = o_m_tdata[59];
            got_word.last_result = o_m_tlast;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %p", $time, got_word);
                mismatch_count++;
            end else begin
                want_word = pending_results.pop_front();
                check_field("kind", 32'(want_word.kind), 32'(got_word.kind));
                check_field("out_offset", want_word.off, got_word.off);
                check_field("out_size", 32'(want_word.size), 32'(got_word.size));
                check_field("out_handle", 32'(want_word.hdl), 32'(got_word.hdl));
                check_field("out_channel", 32'(want_word.chan), 32'(got_word.chan));
                check_field("out_is_last_pkt", 32'(want_word.is_last), 32'(got_word.is_last));
                check_field("last_result", 32'(want_word.last_result),
                            32'(got_word.last_result));
            end
            rx_wait = idle_on ? $urandom_range(0, 9) : 0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cnt = 0;
        end else begin
            stall_cnt++;
            if (stall_cnt >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic test_in_order_basics();
        send_pkt(mk_pkt(32'd0, 11'd100, 1'b0, 8'h00, 8'hFF));
        send_pkt(mk_pkt(next_offset, 11'h7FF, 1'b0, 8'hFF, 8'h00));
        send_pkt(mk_pkt(next_offset, 11'd1025, 1'b0, 8'hA5, 8'h5A));
        send_pkt(mk_pkt(next_offset, 11'd0, 1'b0, 8'h5A, 8'hA5));
        send_pkt(mk_pkt(32'hFFFF_FFFF, 11'd1, 1'b0, 8'h01, 8'h80));
        send_pkt(mk_pkt(next_offset, 11'd1024, 1'b1, 8'h80, 8'h01));
    endtask

    task automatic test_reorder_and_drain();
        logic [OFF_W-1:0] e;
        send_pkt(mk_pkt(32'd300, 11'd50, 1'b0, 8'h13, 8'h31));
        send_pkt(mk_pkt(32'd200, 11'd100, 1'b0, 8'h12, 8'h21));
        send_pkt(mk_pkt(32'd100, 11'd100, 1'b0, 8'h11, 8'h11));
        send_pkt(mk_pkt(32'd0, 11'd100, 1'b0, 8'h10, 8'h01));
        e = next_offset;
        send_pkt(mk_pkt(e + 10, 11'd0, 1'b0, 8'h20, 8'h02));
        send_pkt(mk_pkt(e + 10, 11'd20, 1'b0, 8'h21, 8'h12));
        send_pkt(mk_pkt(e + 10, 11'd30, 1'b0, 8'h22, 8'h22));
        send_pkt(mk_pkt(e, 11'd10, 1'b0, 8'h23, 8'h32));
        send_pkt(mk_pkt(e + 5000, 11'd8, 1'b1, 8'h24, 8'h42));
    endtask

    task automatic test_buffer_full();
        for (int k = BUFFER_DEPTH; k >= 1; k--) begin
            send_pkt(mk_pkt(32'(k * 64), 11'd64, 1'b0, 8'(k), 8'(k + 100)));
        end
        send_pkt(mk_pkt(32'd9999, 11'd1, 1'b0, 8'h77, 8'h77));
        send_pkt(mk_pkt(32'd7777, 11'd1, 1'b1, 8'h78, 8'h78));
        send_pkt(mk_pkt(32'd0, 11'd64, 1'b0, 8'h79, 8'h79));
    endtask

    task automatic test_output_backpressure();
        wait_drain();
        idle_on = 1'b0;
        @(posedge i_clk);
        rx_hold_len = 150;
        @(negedge i_clk);
        for (int k = 0; k < 16; k++) begin
            send_pkt(mk_pkt(next_offset, pick_size(), 1'b0, 8'($urandom), 8'($urandom)));
        end
        wait_drain();
        idle_on = 1'b1;
    endtask

    task automatic test_random_transfers();
        t_pkt             xfer[$];
        t_pkt             tmp;
        logic [OFF_W-1:0] base;
        int               n;
        int               a;
        int               b;
        int               sent;
        sent = 0;
        while (sent < 350) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($countones(slot_used) > 4) begin
                send_pkt(mk_pkt(next_offset, pick_size(), 1'b1, 8'($urandom), 8'($urandom)));
                sent++;
            end
            xfer.delete();
            if ($urandom_range(0, 9) == 0) begin
                repeat (5) begin
                    tmp = mk_pkt($urandom, SIZE_W'($urandom_range(0, 2047)),
                                 ($urandom_range(0, 15) == 0), 8'($urandom), 8'($urandom));
                    xfer.push_back(tmp);
                end
            end else begin
                n = $urandom_range(1, 10);
                base = next_offset;
                for (int k = 0; k < n; k++) begin
                    tmp = mk_pkt(base, pick_size(), (k == n - 1), 8'($urandom), 8'($urandom));
                    base += OFF_W'(clamp_size(tmp.size));
                    xfer.push_back(tmp);
                end
                for (int k = 0; k < n - 1; k++) begin
                    if ($urandom_range(0, 2) == 0) begin
                        tmp = xfer[k];
                        xfer[k] = xfer[k + 1];
                        xfer[k + 1] = tmp;
                    end
                end
                if ($urandom_range(0, 4) == 0) begin
                    a = $urandom_range(0, n - 1);
                    b = $urandom_range(0, n - 1);
                    tmp = xfer[a];
                    xfer[a] = xfer[b];
                    xfer[b] = tmp;
                end
                if ($urandom_range(0, 7) == 0) begin
                    xfer.insert($urandom_range(0, n - 1), xfer[$urandom_range(0, n - 1)]);
                end
            end
            foreach (xfer[k]) begin
                send_pkt(xfer[k]);
                sent++;
            end
            if ($urandom_range(0, 7) == 0) wait_drain();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_in_order_basics();
        test_reorder_and_drain();
        test_buffer_full();
        test_output_backpressure();
        test_random_transfers();
        wait_drain();
        if (pending_results.size() != 0) begin
            $display("%0t: %0d words expected but never seen, next expected %p",
                     $time, pending_results.size(), pending_results[0]);
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
